/* rtl/bda_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the binary-to-decimal ASCII unit.
// No dependencies; every other file imports this package.
package bda_pkg;

   localparam int VALUE_BITS = 32;
   localparam int REQ_BITS   = 32;
   localparam int CHAR_BITS  = 6;

   // Decimal digits needed for the largest VALUE_BITS-bit value.
   function automatic int digit_count(input int bits);
      longint unsigned v;
      int              n;
      v = (bits >= 64) ? '1 : ((64'd1 << bits) - 64'd1);
      n = 1;
      while (v >= 64'd10) begin
         v = v / 64'd10;
         n = n + 1;
      end
      return n;
   endfunction

   localparam int DIGITS   = digit_count(VALUE_BITS);
   localparam int BIT_CW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIG_CW   = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
   localparam logic [3:0]           ADJ_LIMIT  = 4'd5;
   localparam logic [3:0]           ADJ_ADD    = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } bda_state_type;

   // Control broadcast to every digit cell.
   typedef struct packed {
      logic clear;    // zero the digit
      logic convert;  // one double-dabble step
      logic shift;    // move digits one cell toward the top
      logic bin_bit;  // next binary bit into the bottom cell
   } bda_ctrl_type;

   typedef struct packed {
      logic valid;
      logic last;
   } bda_emit_type;

endpackage

/* rtl/bda_cell.sv */
`timescale 1ns / 1ps
// One BCD digit cell of the conversion chain.
// Depends on bda_pkg.
module bda_cell (
   input  logic                  clock,
   input  bda_pkg::bda_ctrl_type ctrl,
   input  logic                  carry_in,
   input  logic [3:0]            digit_in,
   output logic                  carry_out,
   output logic [3:0]            digit
);
   import bda_pkg::*;

   logic [3:0] digit_ff;
   logic [3:0] digit_ff_in;
   logic [3:0] adj;

   // Add three when the digit would overflow past nine after doubling.
   assign adj       = (digit_ff >= ADJ_LIMIT) ? (digit_ff + ADJ_ADD) : digit_ff;
   assign carry_out = adj[3];
   assign digit     = digit_ff;

   always_comb begin
      digit_ff_in = digit_ff;
      if (ctrl.clear) begin
         digit_ff_in = 4'd0;
      end else if (ctrl.convert) begin
         digit_ff_in = {adj[2:0], carry_in};
      end else if (ctrl.shift) begin
         digit_ff_in = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_ff_in;
   end

endmodule

/* rtl/bda_seq.sv */
`timescale 1ns / 1ps
// Sequencer: binary shift register, step counters and the convert/emit FSM.
// Depends on bda_pkg.
module bda_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bda_pkg::REQ_BITS-1:0]  req_number,
   input  logic [3:0]                    top_digit,
   output logic                          busy,
   output bda_pkg::bda_ctrl_type         ctrl,
   output bda_pkg::bda_emit_type         emit
);
   import bda_pkg::*;

   bda_state_type         state_ff, state_ff_in;
   logic [VALUE_BITS-1:0] value_ff, value_ff_in;
   logic [BIT_CW-1:0]     bit_cnt_ff, bit_cnt_ff_in;
   logic [DIG_CW-1:0]     dig_cnt_ff, dig_cnt_ff_in;
   logic                  seen_ff, seen_ff_in;
   logic                  accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_ff_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_ff_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_ff_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (dig_cnt_ff == '0) state_ff_in = ST_IDLE;
         end
         default: state_ff_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath next values.
   always_comb begin
      busy          = 1'b1;
      ctrl          = '0;
      emit          = '0;
      value_ff_in   = value_ff;
      bit_cnt_ff_in = bit_cnt_ff;
      dig_cnt_ff_in = dig_cnt_ff;
      seen_ff_in    = seen_ff;
      ctrl.bin_bit  = value_ff[VALUE_BITS-1];
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               ctrl.clear    = 1'b1;
               value_ff_in   = VALUE_BITS'(req_number);
               bit_cnt_ff_in = BIT_CW'(VALUE_BITS - 1);
            end
         end
         ST_CONVERT: begin
            ctrl.convert  = 1'b1;
            value_ff_in   = value_ff << 1;
            bit_cnt_ff_in = bit_cnt_ff - 1'b1;
            dig_cnt_ff_in = DIG_CW'(DIGITS - 1);
            seen_ff_in    = 1'b0;
         end
         ST_EMIT: begin
            // Drop leading zeros; the final digit always goes out.
            ctrl.shift    = 1'b1;
            emit.last     = (dig_cnt_ff == '0);
            emit.valid    = seen_ff || (top_digit != 4'd0) || emit.last;
            seen_ff_in    = seen_ff || emit.valid;
            dig_cnt_ff_in = dig_cnt_ff - 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_ff_in;
      bit_cnt_ff <= bit_cnt_ff_in;
      dig_cnt_ff <= dig_cnt_ff_in;
      seen_ff    <= seen_ff_in;
   end

endmodule

/* rtl/binary_to_decimal_ascii_unit.sv */
`timescale 1ns / 1ps
// A number runs through 32 double-dabble steps, then 10 digit shifts; each character is
// registered before it leaves. A new number is taken only once the sequencer is idle again,
// with the bit-serial conversion through the digit cell chain and the one-cell-per-cycle
// read-out done; characters leave back to back.
// Reset (synchronous) returns the sequencer to idle and drops the result strobe.
// Depends on bda_pkg, bda_cell and bda_seq.
module binary_to_decimal_ascii_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [bda_pkg::REQ_BITS-1:0]   req_number,
   output logic                           rsp_valid,
   output logic [bda_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   output logic                           rsp_last
);
   import bda_pkg::*;

   bda_ctrl_type         ctrl;
   bda_emit_type         emit;
   logic [3:0]           digit [DIGITS];
   logic                 carry [DIGITS+1];
   logic [3:0]           top_digit;

   logic                 rsp_valid_ff, rsp_valid_ff_in;
   logic                 rsp_last_ff, rsp_last_ff_in;
   logic [CHAR_BITS-1:0] rsp_char_ff, rsp_char_ff_in;

   // Sequencer: takes the start beat, walks the binary bits, then the digits.
   bda_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_number (req_number),
      .top_digit  (top_digit),
      .busy       (busy),
      .ctrl       (ctrl),
      .emit       (emit)
   );

   // Chain of BCD cells, cell 0 holds the least significant digit.
   // Converting: binary bits ripple up through the carries.
   // Emitting: digits advance one cell toward the top each cycle.
   assign carry[0]  = ctrl.bin_bit;
   assign top_digit = digit[DIGITS-1];

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      logic [3:0] below;
      if (i == 0) begin : g_bottom
         assign below = 4'd0;
      end else begin : g_upper
         assign below = digit[i-1];
      end
      bda_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  (carry[i]),
         .digit_in  (below),
         .carry_out (carry[i+1]),
         .digit     (digit[i])
      );
   end

   // Register the result beat; the top cell's digit becomes its ASCII code.
   always_comb begin
      rsp_valid_ff_in = emit.valid;
      rsp_last_ff_in  = emit.last;
      rsp_char_ff_in  = ASCII_ZERO + CHAR_BITS'(top_digit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= rsp_last_ff_in;
      rsp_char_ff <= rsp_char_ff_in;
   end

   // Carry out of the top cell never fires while converting in-range values; leave it unread.
   logic unused_carry;
   assign unused_carry = carry[DIGITS];

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_last       = rsp_last_ff & rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;

endmodule

/* rtl/bda_checker.sv */
`timescale 1ns / 1ps
// Port-level checks on the binary-to-decimal ASCII unit, bound to its top level.
// Depends on bda_pkg.
module bda_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [bda_pkg::CHAR_BITS-1:0]  rsp_digit_char,
   input logic                           rsp_last
);
   import bda_pkg::*;

   // Reset drops the result strobe.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A taken start beat makes the unit busy and shows no beat next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("start beat not followed by busy");

   // Every character is a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= ASCII_ZERO) &&
                     (rsp_digit_char <= ASCII_ZERO + CHAR_BITS'(9))))
      else $error("character outside 0..9");

   // Characters of one number come back to back until the last one.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a number's characters");

   // Results only appear while a number is in flight or just finishing.
   a_no_idle_beat: assert property (@(posedge clock) disable iff (reset)
      (!busy && !rsp_valid && !start) |=> !rsp_valid)
      else $error("result beat while idle");

endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last)
);
